[rtl/core/sbus_frame_decoder_unit_assert.svh]
// Assertion macros shared by the SBUS frame decoder RTL.
`ifndef SBUS_FRAME_DECODER_UNIT_ASSERT_SVH
`define SBUS_FRAME_DECODER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted
`define SBUS_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define SBUS_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/sbus_pkg.sv]
// Package: types, constants and state encoding of the SBUS frame decoder.
`default_nettype none

package sbus_pkg;

    // Frame layout
    localparam int unsigned POS_W        = 5;
    localparam logic [4:0]  LAST_POS     = 5'd24;
    localparam logic [4:0]  FLAG_POS     = 5'd23;
    localparam logic [4:0]  FIRST_DATA   = 5'd1;
    localparam logic [4:0]  DATA_END     = 5'd23;
    localparam logic [7:0]  START_BYTE   = 8'h0F;
    localparam logic [7:0]  END_BYTE     = 8'h00;

    // Channel unpacking
    localparam int unsigned CHAN_BITS    = 11;
    localparam int unsigned BUF_W        = 18;
    localparam int unsigned CNT_W        = 5;
    localparam logic [3:0]  LAST_CHAN    = 4'd15;

    // Scaling to Q1.14
    localparam logic [10:0] CLAMP_LO     = 11'd172;
    localparam logic [10:0] CLAMP_HI     = 11'd1811;
    localparam logic [10:0] SPAN         = 11'd1639;
    localparam int unsigned FRAC_BITS    = 14;
    localparam int unsigned EST_W        = 15;
    localparam int unsigned RECIP_SHIFT  = 11;
    // floor(2^(RECIP_SHIFT+FRAC_BITS) / SPAN)
    localparam logic [14:0] RECIP_MUL    = 15'd20472;

    typedef struct packed {
        logic [7:0]  rx_byte;
        logic [63:0] arrival_time;
    } sbus_in_t;

    typedef struct packed {
        logic [3:0]         channel_index;
        logic [10:0]        raw_value;
        logic signed [15:0] scaled_value;
        logic               digital_one;
        logic               digital_two;
        logic               lost_frame;
        logic               failsafe_active;
        logic [31:0]        frame_number;
        logic [63:0]        frame_time;
        logic               last_channel;
    } sbus_out_t;

    typedef enum logic [2:0] {
        ST_RECV,
        ST_FLAG_RD,
        ST_FLAG_CAP,
        ST_UNPACK,
        ST_ACCUM,
        ST_SCALE,
        ST_EMIT
    } sbus_state_t;

endpackage

`default_nettype wire

[rtl/core/sbus_frame_decoder_unit.sv]
// SBUS frame decoder top level: frame store, bit unpacker and result register.
//
// Receives SBUS bytes, one transaction per cycle while collecting a frame. Bytes
// other than 0x0F are dropped until a start byte arrives; that byte and the next
// 24 go into a 25-entry frame memory. A frame that closes with 0x00 bumps the
// good-frame count and is decoded into 16 channel results, channel 0 first;
// other frames are dropped. While decoding, s_ready is low. Decoding walks the
// memory through its single registered read port: the flag byte first, then the
// 22 data bytes one read each into a bit buffer, and each 11-bit channel passes
// through a three-stage scaler. After a good frame's closing byte, input is taken
// again once the flags are read, the data bytes fetched and each channel extracted,
// scaled and loaded into the output register; output stalls add to that time.
// There is no clearing pass after reset.
`default_nettype none

module sbus_frame_decoder_unit (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire sbus_pkg::sbus_in_t s_data,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output sbus_pkg::sbus_out_t     m_data
);

    `include "sbus_frame_decoder_unit_assert.svh"

    sbus_pkg::sbus_state_t state_reg, state_next;

    logic [7:0]  frame_mem [0:24];
    logic [7:0]  rd_data_reg;
    logic [4:0]  rd_addr;

    logic [4:0]  pos_reg;
    logic [31:0] good_frames_reg;
    logic [63:0] frame_time_reg;
    logic [3:0]  flags_reg;
    logic [sbus_pkg::BUF_W-1:0] bitbuf_reg;
    logic [sbus_pkg::CNT_W-1:0] bitcnt_reg;
    logic [4:0]  byte_addr_reg;
    logic [3:0]  chan_reg;
    logic [10:0] raw_reg;
    logic        m_valid_reg;
    sbus_pkg::sbus_out_t m_data_reg;

    logic        in_take;
    logic        byte_store;
    logic        frame_done;
    logic        frame_good;
    logic        have_chan;
    logic        out_free;
    logic        do_fetch;
    logic        do_accum;
    logic        do_flags;
    logic        do_extract;
    logic        emit_load;

    logic        scale_done;
    logic signed [15:0] scale_value;

    // Input qualification
    assign in_take    = s_valid && s_ready;
    assign byte_store = in_take && ((pos_reg != 5'd0) || (s_data.rx_byte == sbus_pkg::START_BYTE));
    assign frame_done = byte_store && (pos_reg == sbus_pkg::LAST_POS);
    assign frame_good = frame_done && (s_data.rx_byte == sbus_pkg::END_BYTE);
    assign have_chan  = bitcnt_reg >= sbus_pkg::CNT_W'(sbus_pkg::CHAN_BITS);
    assign out_free   = !m_valid_reg || m_ready;

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            sbus_pkg::ST_RECV: begin
                if (frame_good) begin
                    state_next = sbus_pkg::ST_FLAG_RD;
                end
            end
            sbus_pkg::ST_FLAG_RD:  state_next = sbus_pkg::ST_FLAG_CAP;
            sbus_pkg::ST_FLAG_CAP: state_next = sbus_pkg::ST_UNPACK;
            sbus_pkg::ST_UNPACK: begin
                state_next = have_chan ? sbus_pkg::ST_SCALE : sbus_pkg::ST_ACCUM;
            end
            sbus_pkg::ST_ACCUM:    state_next = sbus_pkg::ST_UNPACK;
            sbus_pkg::ST_SCALE: begin
                if (scale_done) begin
                    state_next = sbus_pkg::ST_EMIT;
                end
            end
            sbus_pkg::ST_EMIT: begin
                if (out_free) begin
                    state_next = (chan_reg == sbus_pkg::LAST_CHAN) ? sbus_pkg::ST_RECV
                                                                   : sbus_pkg::ST_UNPACK;
                end
            end
            default:               state_next = sbus_pkg::ST_RECV;
        endcase
    end

    // State outputs
    always_comb begin
        s_ready    = 1'b0;
        rd_addr    = 5'd0;
        do_fetch   = 1'b0;
        do_accum   = 1'b0;
        do_flags   = 1'b0;
        do_extract = 1'b0;
        emit_load  = 1'b0;
        case (state_reg)
            sbus_pkg::ST_RECV:     s_ready = 1'b1;
            sbus_pkg::ST_FLAG_RD:  rd_addr = sbus_pkg::FLAG_POS;
            sbus_pkg::ST_FLAG_CAP: do_flags = 1'b1;
            sbus_pkg::ST_UNPACK: begin
                if (have_chan) begin
                    do_extract = 1'b1;
                end else begin
                    do_fetch = 1'b1;
                    rd_addr  = byte_addr_reg;
                end
            end
            sbus_pkg::ST_ACCUM:    do_accum = 1'b1;
            sbus_pkg::ST_SCALE:    ;
            sbus_pkg::ST_EMIT:     emit_load = out_free;
            default:               ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= sbus_pkg::ST_RECV;
        end else begin
            state_reg <= state_next;
        end
    end

    // Frame memory: one write port from the input, one registered read port
    always_ff @(posedge aclk) begin
        if (byte_store) begin
            frame_mem[pos_reg] <= s_data.rx_byte;
        end
        rd_data_reg <= frame_mem[rd_addr];
    end

    // Byte position and good-frame count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg         <= 5'd0;
            good_frames_reg <= 32'd0;
        end else begin
            if (frame_done) begin
                pos_reg <= 5'd0;
            end else if (byte_store) begin
                pos_reg <= pos_reg + 5'd1;
            end
            if (frame_good) begin
                good_frames_reg <= good_frames_reg + 32'd1;
            end
        end
    end

    // Decode sequencing: bit buffer, read address, channel number
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bitcnt_reg    <= '0;
            byte_addr_reg <= sbus_pkg::FIRST_DATA;
            chan_reg      <= 4'd0;
        end else begin
            if (do_flags) begin
                bitcnt_reg    <= '0;
                byte_addr_reg <= sbus_pkg::FIRST_DATA;
                chan_reg      <= 4'd0;
            end
            if (do_fetch) begin
                byte_addr_reg <= byte_addr_reg + 5'd1;
            end
            if (do_accum) begin
                bitcnt_reg <= bitcnt_reg + sbus_pkg::CNT_W'(8);
            end
            if (do_extract) begin
                bitcnt_reg <= bitcnt_reg - sbus_pkg::CNT_W'(sbus_pkg::CHAN_BITS);
            end
            if (emit_load) begin
                chan_reg <= chan_reg + 4'd1;
            end
        end
    end

    // Decode payload registers
    always_ff @(posedge aclk) begin
        if (frame_good) begin
            frame_time_reg <= s_data.arrival_time;
        end
        if (do_flags) begin
            flags_reg  <= rd_data_reg[3:0];
            bitbuf_reg <= '0;
        end
        if (do_accum) begin
            bitbuf_reg <= bitbuf_reg
                | (sbus_pkg::BUF_W'(rd_data_reg) << bitcnt_reg[3:0]);
        end
        if (do_extract) begin
            raw_reg    <= bitbuf_reg[10:0];
            bitbuf_reg <= bitbuf_reg >> sbus_pkg::CHAN_BITS;
        end
    end

    sbus_scaler u_scaler (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (do_extract),
        .raw     (bitbuf_reg[10:0]),
        .done    (scale_done),
        .value   (scale_value)
    );

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (emit_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit_load) begin
            m_data_reg.channel_index   <= chan_reg;
            m_data_reg.raw_value       <= raw_reg;
            m_data_reg.scaled_value    <= scale_value;
            m_data_reg.digital_one     <= flags_reg[0];
            m_data_reg.digital_two     <= flags_reg[1];
            m_data_reg.lost_frame      <= flags_reg[2];
            m_data_reg.failsafe_active <= flags_reg[3];
            m_data_reg.frame_number    <= good_frames_reg;
            m_data_reg.frame_time      <= frame_time_reg;
            m_data_reg.last_channel    <= (chan_reg == sbus_pkg::LAST_CHAN);
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // Checks
    `SBUS_ASSERT_SAME(a_last_flag, aclk, aresetn, m_valid_reg,
        m_data_reg.last_channel == (m_data_reg.channel_index == sbus_pkg::LAST_CHAN),
        "last_channel disagrees with channel_index")
    `SBUS_ASSERT_SAME(a_accum_room, aclk, aresetn, state_reg == sbus_pkg::ST_ACCUM,
        bitcnt_reg < sbus_pkg::CNT_W'(sbus_pkg::CHAN_BITS),
        "bit buffer overfilled on fetch")
    `SBUS_ASSERT_SAME(a_frame_used, aclk, aresetn, emit_load && (chan_reg == sbus_pkg::LAST_CHAN),
        (byte_addr_reg == sbus_pkg::DATA_END) && (bitcnt_reg == '0),
        "frame bytes not consumed exactly at last channel")
    `SBUS_ASSERT_NEXT(a_count_step, aclk, aresetn, frame_good,
        good_frames_reg == $past(good_frames_reg) + 32'd1,
        "good-frame count did not advance by one")

endmodule

`default_nettype wire

[rtl/core/sbus_scaler.sv]
// Three-stage clamp and scale of an 11-bit channel value to signed Q1.14.
`default_nettype none

module sbus_scaler (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               start,
    input  wire logic [10:0]        raw,
    output logic                    done,
    output logic signed [15:0]      value
);

    logic        va_reg, vb_reg, vc_reg;
    logic        neg_a_reg, neg_b_reg;
    logic [10:0] d_a_reg, d_b_reg;
    logic [sbus_pkg::EST_W-1:0] est_reg;
    logic signed [15:0] value_reg;

    logic [10:0] clamped;
    logic [11:0] twice;
    logic        neg;
    logic [11:0] span_diff;
    logic [25:0] prod;
    logic [25:0] num;
    logic [25:0] back;
    logic [25:0] rem;
    logic        corr;
    logic [sbus_pkg::EST_W-1:0] quot;
    logic [15:0] quot_ext;

    // Stage A: clamp, distance from mid-span and its sign
    always_comb begin
        if (raw < sbus_pkg::CLAMP_LO) begin
            clamped = sbus_pkg::CLAMP_LO;
        end else if (raw > sbus_pkg::CLAMP_HI) begin
            clamped = sbus_pkg::CLAMP_HI;
        end else begin
            clamped = raw;
        end
        twice     = {clamped - sbus_pkg::CLAMP_LO, 1'b0};
        neg       = twice < {1'b0, sbus_pkg::SPAN};
        span_diff = neg ? ({1'b0, sbus_pkg::SPAN} - twice)
                        : (twice - {1'b0, sbus_pkg::SPAN});
    end

    // Stage B: reciprocal estimate, low by at most one
    assign prod = 26'(d_a_reg) * 26'(sbus_pkg::RECIP_MUL);

    // Stage C: remainder check and sign
    always_comb begin
        num      = 26'(d_b_reg) << sbus_pkg::FRAC_BITS;
        back     = 26'(est_reg) * 26'(sbus_pkg::SPAN);
        rem      = num - back;
        corr     = rem >= 26'(sbus_pkg::SPAN);
        quot     = est_reg + {{(sbus_pkg::EST_W-1){1'b0}}, corr};
        quot_ext = {1'b0, quot};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
        end else begin
            va_reg <= start;
            vb_reg <= va_reg;
            vc_reg <= vb_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            neg_a_reg <= neg;
            d_a_reg   <= span_diff[10:0];
        end
        if (va_reg) begin
            neg_b_reg <= neg_a_reg;
            d_b_reg   <= d_a_reg;
            est_reg   <= prod[sbus_pkg::RECIP_SHIFT +: sbus_pkg::EST_W];
        end
        if (vb_reg) begin
            value_reg <= neg_b_reg ? $signed(16'd0 - quot_ext) : $signed(quot_ext);
        end
    end

    assign done  = vc_reg;
    assign value = value_reg;

endmodule

`default_nettype wire
